// File: hdl/hkrb_pkg.sv
// Shared types, opcode and status codes, and the German layout table for the report builder.
package hkrb_pkg;

   localparam int unsigned SLOT_COUNT = 6;

   localparam logic [2:0] OP_PRESS_CHAR   = 3'd0;
   localparam logic [2:0] OP_RELEASE_CHAR = 3'd1;
   localparam logic [2:0] OP_PRESS_CODE   = 3'd2;
   localparam logic [2:0] OP_RELEASE_CODE = 3'd3;
   localparam logic [2:0] OP_RELEASE_ALL  = 3'd4;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_UNMAPPED = 2'd1;
   localparam logic [1:0] STATUS_FULL     = 2'd2;

   localparam logic [5:0] ISO_PLACEHOLDER = 6'h03;
   localparam logic [7:0] ISO_USAGE       = 8'h64;
   localparam logic [7:0] RAW_USAGE_BASE  = 8'd136;

   typedef struct packed {
      logic [2:0] opcode;
      logic [7:0] key_code;
   } req_type;

   typedef struct packed {
      logic       report_sent;
      logic [1:0] status;
      logic [7:0] report_modifiers;
      logic [7:0] report_key0;
      logic [7:0] report_key1;
      logic [7:0] report_key2;
      logic [7:0] report_key3;
      logic [7:0] report_key4;
      logic [7:0] report_key5;
   } rsp_type;

   // Bit 7: left shift, bit 6: AltGr, bits 5:0: usage. Zero means unmapped.
   localparam logic [7:0] LAYOUT_ROM [256] = '{
      8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h2a,8'h2b,8'h28,8'h00,8'h00,8'h00,8'h00,8'h00,
      8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
      8'h2c,8'h9e,8'h9f,8'h31,8'ha1,8'ha2,8'ha3,8'hb1,8'ha5,8'ha6,8'hb0,8'h30,8'h36,8'h38,8'h37,8'ha4,
      8'h27,8'h1e,8'h1f,8'h20,8'h21,8'h22,8'h23,8'h24,8'h25,8'h26,8'hb7,8'hb6,8'h03,8'ha7,8'h83,8'had,
      8'h54,8'h84,8'h85,8'h86,8'h87,8'h88,8'h89,8'h8a,8'h8b,8'h8c,8'h8d,8'h8e,8'h8f,8'h90,8'h91,8'h92,
      8'h93,8'h94,8'h95,8'h96,8'h97,8'h98,8'h99,8'h9a,8'h9b,8'h9d,8'h9c,8'h65,8'h6d,8'h66,8'h35,8'hb8,
      8'hae,8'h04,8'h05,8'h06,8'h07,8'h08,8'h09,8'h0a,8'h0b,8'h0c,8'h0d,8'h0e,8'h0f,8'h10,8'h11,8'h12,
      8'h13,8'h14,8'h15,8'h16,8'h17,8'h18,8'h19,8'h1a,8'h1b,8'h1d,8'h1c,8'h64,8'h43,8'h67,8'h70,8'h2a,
      8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h2a,8'h2b,8'h28,8'h00,8'h00,8'h00,8'h00,8'h00,
      8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
      8'h6c,8'hde,8'h46,8'he0,8'h00,8'h00,8'hc3,8'ha0,8'h6f,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
      8'hb5,8'h00,8'h5f,8'h60,8'h2e,8'h50,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
      8'h00,8'h00,8'h00,8'h00,8'hb4,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
      8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'hb3,8'h00,8'h00,8'h00,8'h00,8'h00,8'haf,8'h00,8'h00,8'h2d,
      8'h00,8'h00,8'h00,8'h00,8'h34,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
      8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h33,8'h00,8'h00,8'h00,8'h00,8'h00,8'h2f,8'h48,8'h00,8'h00
   };

endpackage

// File: hdl/hid_keyboard_report_builder.sv
// HID boot keyboard report builder: six key slots and a modifier byte, one event per transfer.
// A request transfer is captured in the input register, and its result is then
// registered in the result register and shown on rsp_valid.
// Throughput: one event per cycle while rsp_stall does not hold the output; the slot compare,
// table lookup and slot update all sit in the single stage between the two registers.
// Reset empties all slots, clears the modifiers and drops both stages.
module hid_keyboard_report_builder
   import hkrb_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic       in_valid_ff, in_valid_in;
   req_type    in_data_ff;
   logic       out_valid_ff, out_valid_in;
   rsp_type    out_data_ff, out_data_in;
   logic [7:0] keys_ff [SLOT_COUNT];
   logic [7:0] keys_in [SLOT_COUNT];
   logic [7:0] mods_ff, mods_in;

   logic       advance;
   logic       accept;

   logic [7:0] entry;
   logic [7:0] rom_usage;
   logic [7:0] rom_mask;
   logic       is_press;
   logic       is_key_op;
   logic       mapped;
   logic [7:0] usage;
   logic [7:0] mod_mask;
   logic [SLOT_COUNT-1:0] hit;
   logic [SLOT_COUNT-1:0] empty;
   logic [SLOT_COUNT-1:0] first_empty;
   logic       present;
   logic       full;
   logic       sent;
   logic [1:0] status;

   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   assign in_valid_in  = accept || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && rsp_stall);

   // Resolve the key event to a usage, a modifier mask and a mapped flag.
   always_comb begin
      entry     = LAYOUT_ROM[in_data_ff.key_code];
      rom_usage = (entry[5:0] == ISO_PLACEHOLDER) ? ISO_USAGE : {2'b00, entry[5:0]};
      rom_mask  = {1'b0, entry[6], 4'b0000, entry[7], 1'b0};
      is_press  = (in_data_ff.opcode == OP_PRESS_CHAR) || (in_data_ff.opcode == OP_PRESS_CODE);
      is_key_op = (in_data_ff.opcode == OP_PRESS_CHAR) || (in_data_ff.opcode == OP_RELEASE_CHAR)
               || (in_data_ff.opcode == OP_PRESS_CODE) || (in_data_ff.opcode == OP_RELEASE_CODE);
      if (((in_data_ff.opcode == OP_PRESS_CODE) || (in_data_ff.opcode == OP_RELEASE_CODE))
          && in_data_ff.key_code[7]) begin
         mapped = 1'b1;
         if (in_data_ff.key_code >= RAW_USAGE_BASE) begin
            usage    = in_data_ff.key_code - RAW_USAGE_BASE;
            mod_mask = 8'h00;
         end else begin
            usage    = 8'h00;
            mod_mask = 8'(1) << in_data_ff.key_code[2:0];
         end
      end else begin
         mapped   = (entry != 8'h00);
         usage    = rom_usage;
         mod_mask = rom_mask;
      end
   end

   always_comb begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
         hit[i]   = (keys_ff[i] == usage);
         empty[i] = (keys_ff[i] == 8'h00);
      end
      first_empty = empty & ~(empty - SLOT_COUNT'(1));
      present     = |hit;
      full        = !present && !(|empty);
   end

   // Next report state and the status of this event.
   always_comb begin
      keys_in = keys_ff;
      mods_in = mods_ff;
      sent    = 1'b0;
      status  = STATUS_OK;
      if (in_data_ff.opcode == OP_RELEASE_ALL) begin
         for (int i = 0; i < SLOT_COUNT; i++) begin
            keys_in[i] = 8'h00;
         end
         mods_in = 8'h00;
         sent    = 1'b1;
      end else if (is_key_op) begin
         if (!mapped) begin
            status = STATUS_UNMAPPED;
         end else if (is_press) begin
            mods_in = mods_ff | mod_mask;
            if (full) begin
               status = STATUS_FULL;
            end else begin
               sent = 1'b1;
               if (!present) begin
                  for (int i = 0; i < SLOT_COUNT; i++) begin
                     if (first_empty[i]) begin
                        keys_in[i] = usage;
                     end
                  end
               end
            end
         end else begin
            mods_in = mods_ff & ~mod_mask;
            sent    = 1'b1;
            if (usage != 8'h00) begin
               for (int i = 0; i < SLOT_COUNT; i++) begin
                  if (hit[i]) begin
                     keys_in[i] = 8'h00;
                  end
               end
            end
         end
      end
   end

   always_comb begin
      out_data_in.report_sent      = sent;
      out_data_in.status           = status;
      out_data_in.report_modifiers = mods_in;
      out_data_in.report_key0      = keys_in[0];
      out_data_in.report_key1      = keys_in[1];
      out_data_in.report_key2      = keys_in[2];
      out_data_in.report_key3      = keys_in[3];
      out_data_in.report_key4      = keys_in[4];
      out_data_in.report_key5      = keys_in[5];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         mods_ff      <= 8'h00;
         for (int i = 0; i < SLOT_COUNT; i++) begin
            keys_ff[i] <= 8'h00;
         end
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            mods_ff <= mods_in;
            keys_ff <= keys_in;
         end
      end
   end

   // Hold payloads while their stage is stalled.
   always_ff @(posedge clock) begin
      if (accept) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule
